>>> design/round_robin_time_slice_scheduler_unit_defines.svh
// Assertion macros shared by the scheduler's checker.
// No dependencies; take this file with an include before any use.
`ifndef ROUND_ROBIN_TIME_SLICE_SCHEDULER_UNIT_DEFINES_SVH
`define ROUND_ROBIN_TIME_SLICE_SCHEDULER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is low
`define RRTS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("scheduler check failed");

// Next-cycle implication, disabled while reset is low
`define RRTS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("scheduler check failed");

`endif

>>> design/rrts_pkg.sv
// Types and codes of the round-robin time-slice scheduler.
// No dependencies; used by the top level and its checker.
`default_nettype none

package rrts_pkg;

    // Operation codes of an input item
    localparam logic FUNC_ADMIT = 1'b0;
    localparam logic FUNC_RUN   = 1'b1;

    // Result status codes
    typedef enum logic [2:0] {
        ST_ADMIT   = 3'd0,
        ST_REQUEUE = 3'd1,
        ST_FINISH  = 3'd2,
        ST_EMPTY   = 3'd3,
        ST_FULL    = 3'd4
    } t_status;

    // Controller states
    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } t_state;

    // One queue entry
    typedef struct packed {
        logic [3:0] id;
        logic [7:0] rem;
        logic [7:0] exe;
    } t_entry;

    localparam logic [7:0]  SLICE_RESET = 8'd3;
    localparam logic [15:0] ELAPSED_MAX = 16'hFFFF;

endpackage

`default_nettype wire

>>> design/round_robin_time_slice_scheduler_unit.sv
// Round-robin ready queue with a programmable time slice per run step.
// Depends on rrts_pkg; the queue lives in a one-port-write, one-port-read memory.
//
//   channel   direction  handshake                 payload
//   in        input      i_in_valid / o_in_ready   i_func, i_proc_id, i_run_time
//   out       output     o_out_valid / i_out_ready o_status, o_out_id, o_remaining,
//                                                  o_executed, o_finish_time
//   cfg       input      i_cfg_we                  i_cfg_data (time slice)
//
// Each item is taken in IDLE, which reads the head entry from the queue memory; in EXEC
// it is charged, written back to the tail and loaded into the result register.
// EXEC is held while the result register is still full and stalled.
// A new item is taken while a finished result waits to be transferred.
// Synchronous active-low reset empties the queue, clears elapsed time and sets
// the time slice to 3; the memory itself is not cleared.
`default_nettype none

module round_robin_time_slice_scheduler_unit #(
    parameter int MAX_PROCS = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic        i_func,
    input  wire logic [3:0]  i_proc_id,
    input  wire logic [7:0]  i_run_time,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [2:0]       o_status,
    output logic [3:0]       o_out_id,
    output logic [7:0]       o_remaining,
    output logic [7:0]       o_executed,
    output logic [15:0]      o_finish_time,
    input  wire logic        i_cfg_we,
    input  wire logic [7:0]  i_cfg_data
);

    localparam int PTR_W = $clog2(MAX_PROCS);
    localparam int CNT_W = $clog2(MAX_PROCS + 1);

    // Queue storage
    rrts_pkg::t_entry r_mem [MAX_PROCS];
    rrts_pkg::t_entry r_rd_data;

    rrts_pkg::t_state   r_state, n_state;
    logic [PTR_W-1:0]   r_head, n_head;
    logic [PTR_W-1:0]   r_tail, n_tail;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [15:0]        r_elapsed, n_elapsed;
    logic [7:0]         r_time_slice;

    // Latched item
    logic               r_func;
    logic [3:0]         r_proc_id;
    logic [7:0]         r_run_time;

    // Result register
    logic               r_out_valid;
    rrts_pkg::t_status  r_status, n_status;
    logic [3:0]         r_out_id, n_out_id;
    logic [7:0]         r_remaining, n_remaining;
    logic [7:0]         r_executed, n_executed;
    logic [15:0]        r_finish_time, n_finish_time;

    logic               in_xfer;
    logic               out_free;
    logic               out_load;
    logic               mem_we;
    rrts_pkg::t_entry   mem_wdata;
    logic [PTR_W-1:0]   head_inc;
    logic [PTR_W-1:0]   tail_inc;
    logic [7:0]         charge;
    logic [7:0]         rem_left;
    logic [7:0]         exe_sum;
    logic [16:0]        el_sum;
    logic [15:0]        el_sat;
    logic               q_full;
    logic               q_empty;

    assign in_xfer  = i_in_valid && o_in_ready;
    assign out_free = !r_out_valid || i_out_ready;
    assign head_inc = (r_head == PTR_W'(MAX_PROCS - 1)) ? '0 : r_head + PTR_W'(1);
    assign tail_inc = (r_tail == PTR_W'(MAX_PROCS - 1)) ? '0 : r_tail + PTR_W'(1);
    assign q_full   = (r_count == CNT_W'(MAX_PROCS));
    assign q_empty  = (r_count == '0);

    // Charge the head entry by at most one slice
    assign charge   = (r_rd_data.rem < r_time_slice) ? r_rd_data.rem : r_time_slice;
    assign rem_left = r_rd_data.rem - charge;
    assign exe_sum  = r_rd_data.exe + charge;
    assign el_sum   = {1'b0, r_elapsed} + {9'd0, charge};
    assign el_sat   = el_sum[16] ? rrts_pkg::ELAPSED_MAX : el_sum[15:0];

    // Next state, queue update and result
    always_comb begin
        n_state       = r_state;
        n_head        = r_head;
        n_tail        = r_tail;
        n_count       = r_count;
        n_elapsed     = r_elapsed;
        mem_we        = 1'b0;
        mem_wdata     = '{id: r_proc_id, rem: r_run_time, exe: 8'd0};
        out_load      = 1'b0;
        n_status      = rrts_pkg::ST_EMPTY;
        n_out_id      = 4'd0;
        n_remaining   = 8'd0;
        n_executed    = 8'd0;
        n_finish_time = 16'd0;
        o_in_ready    = 1'b0;
        unique case (r_state)
            rrts_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_state = rrts_pkg::S_EXEC;
                end
            end
            rrts_pkg::S_EXEC: begin
                if (out_free) begin
                    out_load = 1'b1;
                    n_state  = rrts_pkg::S_IDLE;
                    if (r_func == rrts_pkg::FUNC_ADMIT) begin
                        n_out_id    = r_proc_id;
                        n_remaining = r_run_time;
                        if (q_full) begin
                            n_status = rrts_pkg::ST_FULL;
                        end else begin
                            n_status = rrts_pkg::ST_ADMIT;
                            mem_we   = 1'b1;
                            n_tail   = tail_inc;
                            n_count  = r_count + CNT_W'(1);
                        end
                    end else if (!q_empty) begin
                        n_head     = head_inc;
                        n_elapsed  = el_sat;
                        n_out_id   = r_rd_data.id;
                        n_executed = exe_sum;
                        if (rem_left == 8'd0) begin
                            n_status      = rrts_pkg::ST_FINISH;
                            n_finish_time = el_sat;
                            n_count       = r_count - CNT_W'(1);
                        end else begin
                            n_status    = rrts_pkg::ST_REQUEUE;
                            n_remaining = rem_left;
                            mem_we      = 1'b1;
                            mem_wdata   = '{id: r_rd_data.id, rem: rem_left, exe: exe_sum};
                            n_tail      = tail_inc;
                        end
                    end
                end
            end
            default: n_state = rrts_pkg::S_IDLE;
        endcase
    end

    // Queue memory: write at tail, registered read at head on transfer
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_tail] <= mem_wdata;
        end
        if (in_xfer) begin
            r_rd_data <= r_mem[r_head];
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= rrts_pkg::S_IDLE;
            r_head       <= '0;
            r_tail       <= '0;
            r_count      <= '0;
            r_elapsed    <= 16'd0;
            r_time_slice <= rrts_pkg::SLICE_RESET;
            r_out_valid  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_head    <= n_head;
            r_tail    <= n_tail;
            r_count   <= n_count;
            r_elapsed <= n_elapsed;
            if (i_cfg_we) begin
                r_time_slice <= i_cfg_data;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Hold the accepted item
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_func     <= i_func;
            r_proc_id  <= i_proc_id;
            r_run_time <= i_run_time;
        end
    end

    // Load the result register
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_status      <= n_status;
            r_out_id      <= n_out_id;
            r_remaining   <= n_remaining;
            r_executed    <= n_executed;
            r_finish_time <= n_finish_time;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_status;
    assign o_out_id      = r_out_id;
    assign o_remaining   = r_remaining;
    assign o_executed    = r_executed;
    assign o_finish_time = r_finish_time;

endmodule

`default_nettype wire

>>> design/rrts_checker.sv
// Port-level checks for the round-robin scheduler, bound to its top level.
// Depends on rrts_pkg and the scheduler's assertion macro header.
`default_nettype none
`include "round_robin_time_slice_scheduler_unit_defines.svh"

module rrts_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        o_in_ready,
    input wire logic        o_out_valid,
    input wire logic        i_out_ready,
    input wire logic [2:0]  o_status,
    input wire logic [3:0]  o_out_id,
    input wire logic [7:0]  o_remaining,
    input wire logic [7:0]  o_executed,
    input wire logic [15:0] o_finish_time
);

    logic out_stall;
    logic in_xfer;
    logic out_not_fin;
    logic out_empty;
    logic empty_clean;

    assign out_stall   = o_out_valid && !i_out_ready;
    assign in_xfer     = i_in_valid && o_in_ready;
    assign out_not_fin = o_out_valid && (o_status != rrts_pkg::ST_FINISH);
    assign out_empty   = o_out_valid && (o_status == rrts_pkg::ST_EMPTY);
    assign empty_clean = (o_out_id == 4'd0) && (o_remaining == 8'd0) && (o_executed == 8'd0);

    // A stalled result keeps its status
    `RRTS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_stall, o_out_valid && $stable(o_status))

    // One item at a time: no second transfer right after one
    `RRTS_ASSERT_NEXT(a_one_item, i_clk, i_rst_n, in_xfer, !o_in_ready)

    // Finish time is reported only for a finished process
    `RRTS_ASSERT_SAME(a_fin_zero, i_clk, i_rst_n, out_not_fin, o_finish_time == 16'd0)

    // An empty-queue run reports nothing but its status
    `RRTS_ASSERT_SAME(a_empty_zero, i_clk, i_rst_n, out_empty, empty_clean)

endmodule

bind round_robin_time_slice_scheduler_unit rrts_checker u_rrts_checker (.*);

`default_nettype wire

>>> bench/tb_round_robin_time_slice_scheduler_unit.sv
`timescale 1ns / 1ps
// Self-checking bench for the round-robin time-slice scheduler: a directed run, then
// random phases at several time slices, checked against a scheduler predictor.
// Depends on rrts_pkg and round_robin_time_slice_scheduler_unit.
module tb_round_robin_time_slice_scheduler_unit;

    localparam int QUEUE_DEPTH = 16;
    localparam int CYCLE_LIMIT = 300000;
    localparam int DRAIN_CYCLES = 4;
    localparam int HOLD_CYCLES = 400;
    localparam int HOLD_AFTER_RESULTS = 60;

    // One command on the input channel
    typedef struct {
        logic       func;
        logic [3:0] pid;
        logic [7:0] rt;
    } t_sched_cmd;

    // One scheduler result, field by field
    typedef struct packed {
        rrts_pkg::t_status status;
        logic [3:0]        id;
        logic [7:0]        remaining;
        logic [7:0]        executed;
        logic [15:0]       finish;
    } t_sched_result;

    // Receiver stall patterns
    typedef enum logic [1:0] {
        RX_STREAM,
        RX_COIN,
        RX_SPARSE,
        RX_EVERY_THIRD
    } t_rx_mode;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic        i_func = rrts_pkg::FUNC_ADMIT;
    logic [3:0]  i_proc_id = '0;
    logic [7:0]  i_run_time = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [2:0]  o_status;
    logic [3:0]  o_out_id;
    logic [7:0]  o_remaining;
    logic [7:0]  o_executed;
    logic [15:0] o_finish_time;
    logic        i_cfg_we = 1'b0;
    logic [7:0]  i_cfg_data = '0;

    // Predictor state
    rrts_pkg::t_entry ready_procs[$];
    logic [15:0]      sched_elapsed = '0;
    logic [7:0]       sched_slice = rrts_pkg::SLICE_RESET;

    t_sched_cmd    pending_cmds[$];
    t_sched_result expected_results[$];

    int cmds_sent = 0;
    int results_checked = 0;
    int mismatches = 0;
    int status_hits[5] = '{default: 0};
    int cycle_count = 0;

    // Sender and receiver pacing
    int       burst_left = 8;
    int       gap_left = 0;
    int       hold_left = 0;
    bit       hold_done = 1'b0;
    int       mode_left = 0;
    t_rx_mode rx_mode = RX_STREAM;

    round_robin_time_slice_scheduler_unit #(
        .MAX_PROCS(QUEUE_DEPTH)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_func       (i_func),
        .i_proc_id    (i_proc_id),
        .i_run_time   (i_run_time),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_status     (o_status),
        .o_out_id     (o_out_id),
        .o_remaining  (o_remaining),
        .o_executed   (o_executed),
        .o_finish_time(o_finish_time),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // Advance the scheduler predictor by one command and return its result
    function automatic t_sched_result schedule_step(input logic func,
                                                    input logic [3:0] pid,
                                                    input logic [7:0] rt);
        rrts_pkg::t_entry cur;
        logic [7:0]       charge;
        logic [16:0]      sum;
        t_sched_result    res;
        res = '0;
        if (func == rrts_pkg::FUNC_ADMIT) begin
            res.id = pid;
            res.remaining = rt;
            if (ready_procs.size() >= QUEUE_DEPTH) begin
                res.status = rrts_pkg::ST_FULL;
            end else begin
                cur.id = pid;
                cur.rem = rt;
                cur.exe = '0;
                ready_procs.push_back(cur);
                res.status = rrts_pkg::ST_ADMIT;
            end
        end else if (ready_procs.size() == 0) begin
            res.status = rrts_pkg::ST_EMPTY;
        end else begin
            cur = ready_procs.pop_front();
            charge = (cur.rem < sched_slice) ? cur.rem : sched_slice;
            cur.rem = cur.rem - charge;
            cur.exe = cur.exe + charge;
            sum = {1'b0, sched_elapsed} + charge;
            sched_elapsed = (sum > rrts_pkg::ELAPSED_MAX) ? rrts_pkg::ELAPSED_MAX : sum[15:0];
            res.id = cur.id;
            res.executed = cur.exe;
            if (cur.rem == 0) begin
                res.status = rrts_pkg::ST_FINISH;
                res.finish = sched_elapsed;
            end else begin
                res.status = rrts_pkg::ST_REQUEUE;
                res.remaining = cur.rem;
                ready_procs.push_back(cur);
            end
        end
        return res;
    endfunction

    task automatic queue_cmd(input logic func, input logic [3:0] pid, input logic [7:0] rt);
        t_sched_cmd cmd;
        cmd.func = func;
        cmd.pid = pid;
        cmd.rt = rt;
        pending_cmds.push_back(cmd);
    endtask

    // Run times lean toward the corners: zero, full scale and short jobs
    function automatic logic [7:0] random_run_time();
        case ($urandom_range(0, 9))
            0: return 8'd0;
            1: return 8'hFF;
            2, 3, 4: return 8'($urandom_range(1, 8));
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic queue_random(input int count, input int admit_pct);
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(0, 99) < admit_pct)
                queue_cmd(rrts_pkg::FUNC_ADMIT, 4'($urandom), random_run_time());
            else
                queue_cmd(rrts_pkg::FUNC_RUN, 4'($urandom), 8'($urandom));
        end
    endtask

    // Hold until every command is taken and every result is back, then let the block settle
    task automatic wait_drained();
        @(negedge i_clk);
        while (pending_cmds.size() != 0 || i_in_valid || expected_results.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_slice(input logic [7:0] value);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_data <= value;
        sched_slice = value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            mismatches++;
        end
    endtask

    // Input driver: offer queued commands in bursts, hold each one until it transfers
    always @(posedge i_clk) begin : drive_cmds
        t_sched_cmd cmd;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            i_func <= rrts_pkg::FUNC_ADMIT;
            i_proc_id <= '0;
            i_run_time <= '0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                expected_results.push_back(schedule_step(i_func, i_proc_id, i_run_time));
                cmds_sent++;
            end
            if (i_in_valid && !o_in_ready) begin
                // hold the current command
            end else if (gap_left > 0) begin
                gap_left--;
                i_in_valid <= 1'b0;
            end else if (pending_cmds.size() != 0) begin
                cmd = pending_cmds.pop_front();
                i_in_valid <= 1'b1;
                i_func <= cmd.func;
                i_proc_id <= cmd.pid;
                i_run_time <= cmd.rt;
                burst_left--;
                if (burst_left <= 0) begin
                    burst_left = $urandom_range(1, 40);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
                end
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Output ready: switch stall patterns now and then, and hold off once for a long stretch
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (!hold_done && results_checked >= HOLD_AFTER_RESULTS) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    rx_mode = t_rx_mode'($urandom_range(0, 3));
                    mode_left = $urandom_range(16, 96);
                end
                mode_left--;
                case (rx_mode)
                    RX_STREAM: i_out_ready <= 1'b1;
                    RX_COIN: i_out_ready <= 1'($urandom_range(0, 1));
                    RX_SPARSE: i_out_ready <= ($urandom_range(0, 4) == 0);
                    default: i_out_ready <= (mode_left % 3 == 0);
                endcase
            end
        end
    end

    // Result checker: compare each transfer with the oldest prediction
    always @(posedge i_clk) begin : check_results
        t_sched_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_results.size() == 0) begin
                $error("unexpected result: status %0d id %0d", o_status, o_out_id);
                mismatches++;
            end else begin
                want = expected_results.pop_front();
                check_field("status", 16'(want.status), 16'(o_status));
                check_field("out_id", 16'(want.id), 16'(o_out_id));
                check_field("remaining", 16'(want.remaining), 16'(o_remaining));
                check_field("executed", 16'(want.executed), 16'(o_executed));
                check_field("finish_time", want.finish, o_finish_time);
                status_hits[want.status]++;
                results_checked++;
            end
        end
    end

    always @(posedge i_clk) cycle_count <= cycle_count + 1;

    initial begin
        wait (cycle_count == CYCLE_LIMIT);
        $display("timeout after %0d cycles", cycle_count);
        $display("round_robin_time_slice_scheduler_unit regression: fail");
        $finish;
    end

    // Stimulus: directed corners first, then random phases at several time slices
    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Run on an empty queue, then a zero run-time process that finishes at once
        queue_cmd(rrts_pkg::FUNC_RUN, 4'hA, 8'h5C);
        queue_cmd(rrts_pkg::FUNC_ADMIT, 4'd0, 8'd0);
        queue_cmd(rrts_pkg::FUNC_RUN, 4'h3, 8'hA3);
        // Long job requeues, short ones finish below and exactly at the slice
        queue_cmd(rrts_pkg::FUNC_ADMIT, 4'd15, 8'd255);
        queue_cmd(rrts_pkg::FUNC_ADMIT, 4'd5, 8'd1);
        queue_cmd(rrts_pkg::FUNC_ADMIT, 4'd10, 8'd3);
        queue_cmd(rrts_pkg::FUNC_RUN, 4'hF, 8'hFF);
        queue_cmd(rrts_pkg::FUNC_RUN, 4'h0, 8'h00);
        queue_cmd(rrts_pkg::FUNC_RUN, 4'h6, 8'h81);
        // Fill the queue, then one admit too many
        for (int i = 1; i < QUEUE_DEPTH; i++)
            queue_cmd(rrts_pkg::FUNC_ADMIT, 4'(i), 8'(i * 17));
        queue_cmd(rrts_pkg::FUNC_ADMIT, 4'd6, 8'd200);
        wait_drained();

        // Zero slice: runs charge nothing
        write_slice(8'd0);
        queue_random(24, 50);
        wait_drained();

        // Widest slice, run-heavy: every run finishes
        write_slice(8'd255);
        queue_random(80, 35);
        wait_drained();

        // Narrowest nonzero slice, admit-heavy: the queue fills and rejects
        write_slice(8'd1);
        queue_random(60, 65);
        wait_drained();

        write_slice(8'($urandom_range(2, 254)));
        queue_random(60, 50);
        wait_drained();

        // Push elapsed time into saturation with admit/run pairs, then run past it
        write_slice(8'd255);
        while (sched_elapsed != rrts_pkg::ELAPSED_MAX) begin
            repeat (20) begin
                queue_cmd(rrts_pkg::FUNC_ADMIT, 4'($urandom),
                          ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'd255);
                queue_cmd(rrts_pkg::FUNC_RUN, 4'($urandom), 8'($urandom));
            end
            wait_drained();
        end
        write_slice(rrts_pkg::SLICE_RESET);
        queue_random(40, 50);
        wait_drained();

        $display("covered %0d commands, %0d results: admit %0d requeue %0d finish %0d",
                 cmds_sent, results_checked, status_hits[rrts_pkg::ST_ADMIT],
                 status_hits[rrts_pkg::ST_REQUEUE], status_hits[rrts_pkg::ST_FINISH]);
        $display("empty %0d full %0d; slices 0, 1, 3, 255 and one random; elapsed ended at %0d",
                 status_hits[rrts_pkg::ST_EMPTY], status_hits[rrts_pkg::ST_FULL],
                 sched_elapsed);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("round_robin_time_slice_scheduler_unit regression: pass");
        else
            $display("round_robin_time_slice_scheduler_unit regression: fail");
        $finish;
    end

endmodule
